/* rtl/rrtt_pkg.sv */
// ============================================================================
// rrtt_pkg: shared types and constants for the round-robin task table
// Slot states, operation and status codes, the slot file write bundle and the result bundle.
// ============================================================================
`default_nettype none

package rrtt_pkg;

    localparam int NUM_SLOTS = 16;
    localparam int IDLE_SLOT = 0;
    localparam int SLOT_W    = $clog2(NUM_SLOTS);
    localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

    // Fixed field widths of the channel payloads
    localparam int OP_W     = 2;
    localparam int TID_W    = 4;
    localparam int STATUS_W = 2;
    localparam int IDX_W    = 4;

    localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
    localparam logic [OP_W-1:0] OP_SWITCH = 2'd2;

    typedef enum logic [1:0] {
        ST_EMPTY   = 2'd0,
        ST_READY   = 2'd1,
        ST_RUNNING = 2'd2,
        ST_DELETED = 2'd3
    } t_slot_st;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_NO_TASK   = 2'd2,
        STAT_IDLE_PROT = 2'd3
    } t_status;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] addr;
        t_slot_st          data;
    } t_slot_wr;

    typedef struct packed {
        t_status          status;
        logic [IDX_W-1:0] slot_index;
        logic             switch_request;
    } t_result;

endpackage

`default_nettype wire

/* rtl/rrtt_in_if.sv */
// ============================================================================
// rrtt_in_if: request channel of the task table
// valid/ready handshake carrying one operation beat.
// ============================================================================
`default_nettype none

interface rrtt_in_if;
    logic                       valid;
    logic                       ready;
    logic [rrtt_pkg::OP_W-1:0]  operation;
    logic [rrtt_pkg::TID_W-1:0] task_id;

    modport source (output valid, output operation, output task_id, input ready);
    modport sink   (input valid, input operation, input task_id, output ready);
endinterface

`default_nettype wire

/* rtl/rrtt_out_if.sv */
// ============================================================================
// rrtt_out_if: response channel of the task table
// valid/ready handshake carrying one result beat.
// ============================================================================
`default_nettype none

interface rrtt_out_if;
    logic                          valid;
    logic                          ready;
    logic [rrtt_pkg::STATUS_W-1:0] status;
    logic [rrtt_pkg::IDX_W-1:0]    slot_index;
    logic                          switch_request;

    modport source (output valid, output status, output slot_index,
                    output switch_request, input ready);
    modport sink   (input valid, input status, input slot_index,
                    input switch_request, output ready);
endinterface

`default_nettype wire

/* rtl/round_robin_task_table_top.sv */
// ============================================================================
// round_robin_task_table_top: round-robin task slot table
// Create / delete / switch on a small slot table, one slot examined per cycle.
// ============================================================================
//
//  channel  | dir | beat contents                            | handshake
//  ---------+-----+------------------------------------------+-----------
//  i_in     | in  | operation, task_id                       | valid/ready
//  o_out    | out | status, slot_index, switch_request       | valid/ready
//
//  Sequencing: a beat is taken only in IDLE. The sequencer walks the slot
//  file through its single read port, one slot per cycle. A full-table
//  create, an unused code and an idle delete go straight to the result;
//  create scans for a deleted slot or appends, switch searches for a ready
//  slot, delete of a live slot marks it deleted, and deleting the running
//  slot goes on into a switch.
//  Reset: synchronous, active low; slot 0 ready, all others empty.
//  Stalls: the result sits in an output register, so a new request beat is
//  accepted while the previous result waits for o_out.ready.
// ============================================================================
`default_nettype none

module round_robin_task_table_top (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rrtt_in_if.sink   i_in,
    rrtt_out_if.source o_out
);

    localparam int SW = rrtt_pkg::SLOT_W;
    localparam int CW = rrtt_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CRT,      // scan for lowest deleted slot, else append
        S_DEL,      // check the target slot
        S_RET,      // return running slot to ready
        S_SCAN,     // cyclic search for a ready slot
        S_DONE      // hand result to the output register
    } t_state;

    t_state              r_state, n_state;
    logic [SW-1:0]       r_idx, n_idx;          // slot file read address
    logic [CW-1:0]       r_step, n_step;        // scan steps taken
    logic [CW-1:0]       r_used, n_used;
    logic [SW-1:0]       r_running, n_running;
    logic                r_started, n_started;
    rrtt_pkg::t_result   r_res, n_res;          // finished result, pending
    logic                r_o_valid, n_o_valid;
    rrtt_pkg::t_result   r_o, n_o;

    rrtt_pkg::t_slot_wr  slot_wr;
    rrtt_pkg::t_slot_st  slot_rd;

    logic                in_acc;
    logic [CW-1:0]       idx_inc;
    logic [SW-1:0]       idx_next;              // (r_idx + 1) mod used_count
    logic [CW-1:0]       tid_ext;

    rrtt_slot_file u_slots (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (r_idx),
        .i_wr      (slot_wr),
        .o_rd_data (slot_rd)
    );

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    // running slot is always below used_count, so a wrap to zero is the modulo
    assign idx_inc  = CW'(r_idx) + CW'(1);
    assign idx_next = (idx_inc >= r_used) ? '0 : SW'(idx_inc);
    assign tid_ext  = CW'(i_in.task_id);

    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_step    = r_step;
        n_used    = r_used;
        n_running = r_running;
        n_started = r_started;
        n_res     = r_res;
        n_o_valid = r_o_valid;
        n_o       = r_o;
        slot_wr   = '{en: 1'b0, addr: r_idx, data: rrtt_pkg::ST_READY};

        if (o_out.ready) begin
            n_o_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res = '{status: rrtt_pkg::STAT_OK,
                              slot_index: rrtt_pkg::IDX_W'(r_running),
                              switch_request: 1'b0};
                    case (i_in.operation)
                        rrtt_pkg::OP_CREATE: begin
                            if (r_used >= CW'(rrtt_pkg::NUM_SLOTS)) begin
                                n_res.status     = rrtt_pkg::STAT_FULL;
                                n_res.slot_index = '0;
                                n_state          = S_DONE;
                            end else begin
                                n_idx   = '0;
                                n_state = S_CRT;
                            end
                        end
                        rrtt_pkg::OP_DELETE: begin
                            if (tid_ext >= CW'(rrtt_pkg::NUM_SLOTS)) begin
                                n_res.status = rrtt_pkg::STAT_NO_TASK;
                                n_state      = S_DONE;
                            end else if (tid_ext == CW'(rrtt_pkg::IDLE_SLOT)) begin
                                n_res.status = rrtt_pkg::STAT_IDLE_PROT;
                                n_state      = S_DONE;
                            end else begin
                                n_idx   = SW'(i_in.task_id);
                                n_state = S_DEL;
                            end
                        end
                        rrtt_pkg::OP_SWITCH: begin
                            n_idx   = r_running;
                            n_state = S_RET;
                        end
                        default: begin
                            n_state = S_DONE;   // unused code: no effect
                        end
                    endcase
                end
            end

            S_CRT: begin
                if (slot_rd == rrtt_pkg::ST_DELETED) begin
                    slot_wr          = '{en: 1'b1, addr: r_idx, data: rrtt_pkg::ST_READY};
                    n_res.slot_index = rrtt_pkg::IDX_W'(r_idx);
                    n_state          = S_DONE;
                end else if (CW'(r_idx) == r_used) begin
                    // append at the end of the used range
                    slot_wr          = '{en: 1'b1, addr: r_idx, data: rrtt_pkg::ST_READY};
                    n_used           = r_used + CW'(1);
                    n_res.slot_index = rrtt_pkg::IDX_W'(r_idx);
                    n_state          = S_DONE;
                end else begin
                    n_idx = SW'(idx_inc);
                end
            end

            S_DEL: begin
                if (slot_rd == rrtt_pkg::ST_EMPTY || slot_rd == rrtt_pkg::ST_DELETED) begin
                    n_res.status = rrtt_pkg::STAT_NO_TASK;
                    n_state      = S_DONE;
                end else begin
                    slot_wr = '{en: 1'b1, addr: r_idx, data: rrtt_pkg::ST_DELETED};
                    if (r_idx == r_running) begin
                        n_state = S_RET;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end

            S_RET: begin
                // r_idx holds the running slot here
                if (slot_rd == rrtt_pkg::ST_RUNNING) begin
                    slot_wr = '{en: 1'b1, addr: r_idx, data: rrtt_pkg::ST_READY};
                end
                n_idx   = idx_next;
                n_step  = CW'(1);
                n_state = S_SCAN;
            end

            S_SCAN: begin
                if (slot_rd == rrtt_pkg::ST_READY) begin
                    slot_wr   = '{en: 1'b1, addr: r_idx, data: rrtt_pkg::ST_RUNNING};
                    n_running = r_idx;
                    n_started = 1'b1;
                    n_res.slot_index     = rrtt_pkg::IDX_W'(r_idx);
                    n_res.switch_request = r_started && (r_idx != r_running);
                    n_state   = S_DONE;
                end else if (r_step >= r_used) begin
                    // nothing ready: keep the running slot
                    n_started = 1'b1;
                    n_state   = S_DONE;
                end else begin
                    n_idx  = idx_next;
                    n_step = r_step + CW'(1);
                end
            end

            S_DONE: begin
                if (!r_o_valid || o_out.ready) begin
                    n_o_valid = 1'b1;
                    n_o       = r_res;
                    n_state   = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_used    <= CW'(1);
            r_running <= SW'(rrtt_pkg::IDLE_SLOT);
            r_started <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_used    <= n_used;
            r_running <= n_running;
            r_started <= n_started;
            r_o_valid <= n_o_valid;
        end
        r_idx  <= n_idx;
        r_step <= n_step;
        r_res  <= n_res;
        r_o    <= n_o;
    end

    assign o_out.valid          = r_o_valid;
    assign o_out.status         = r_o.status;
    assign o_out.slot_index     = r_o.slot_index;
    assign o_out.switch_request = r_o.switch_request;

endmodule

`default_nettype wire

/* rtl/rrtt_slot_file.sv */
// ============================================================================
// rrtt_slot_file: per-slot state register file
// One read address, one write port; reset leaves the idle slot ready.
// ============================================================================
`default_nettype none

module rrtt_slot_file (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [rrtt_pkg::SLOT_W-1:0]   i_rd_addr,
    input  wire rrtt_pkg::t_slot_wr            i_wr,
    output rrtt_pkg::t_slot_st                 o_rd_data
);

    rrtt_pkg::t_slot_st r_slot [rrtt_pkg::NUM_SLOTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < rrtt_pkg::NUM_SLOTS; i++) begin
                r_slot[i] <= (i == rrtt_pkg::IDLE_SLOT) ? rrtt_pkg::ST_READY
                                                        : rrtt_pkg::ST_EMPTY;
            end
        end else if (i_wr.en) begin
            r_slot[i_wr.addr] <= i_wr.data;
        end
    end

    assign o_rd_data = r_slot[i_rd_addr];

endmodule

`default_nettype wire

/* rtl/rrtt_checker.sv */
// ============================================================================
// rrtt_checker: port-level checks for the round-robin task table
// Watches both channels; bound to the top level below.
// ============================================================================
`default_nettype none

module rrtt_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          i_in_ready,
    input wire logic                          i_out_valid,
    input wire logic                          i_out_ready,
    input wire logic [rrtt_pkg::STATUS_W-1:0] i_status,
    input wire logic [rrtt_pkg::IDX_W-1:0]    i_slot_index,
    input wire logic                          i_switch_request
);

    // a switch request only comes with a successful operation
    a_req_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_switch_request) |-> (i_status == rrtt_pkg::STAT_OK))
        else $error("switch request with non-ok status");

    // a full table answers slot 0
    a_full_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_status == rrtt_pkg::STAT_FULL) |-> (i_slot_index == '0))
        else $error("full status with nonzero slot");

    // the sequencer is busy right after taking a beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> !i_in_ready)
        else $error("ready right after accept");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_status) && $stable(i_slot_index)
             && $stable(i_switch_request)))
        else $error("result changed under stall");

endmodule

bind round_robin_task_table_top rrtt_checker u_rrtt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in.valid),
    .i_in_ready       (i_in.ready),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_status         (o_out.status),
    .i_slot_index     (o_out.slot_index),
    .i_switch_request (o_out.switch_request)
);

`default_nettype wire
